FILE: rtl/swpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_pkg
// Shared types and constants of the sliding window percentile tracker.
// ----------------------------------------------------------------------------
package swpt_pkg;

  localparam int WINDOW   = 256;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 32;
  localparam int QUANT_W  = 17;
  localparam int QFRAC_W  = 16;
  localparam int COUNT_W  = 40;
  localparam int SUM_W    = 56;
  localparam int WFILL_W  = 9;

  // Rank readout: registered OR over groups of cells, then over groups.
  localparam int GROUP = 16;
  localparam int NGRP  = (WINDOW + GROUP - 1) / GROUP;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } swpt_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_GATHER,
    ST_REDUCE,
    ST_EMIT
  } swpt_state_t;

  // Order flags one cell hands to its neighbors.
  typedef struct packed {
    logic gt;  // cell lies above the new sample (or is empty)
    logic ge;  // cell lies at or above the evicted sample when full, else is empty
  } swpt_flags_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                upd;
    logic                full;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] evict;
  } swpt_ctrl_t;

endpackage

FILE: rtl/swpt_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_item_if
// Input channel: one word records a sample or queries a percentile.
// ----------------------------------------------------------------------------
interface swpt_item_if import swpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SAMPLE_W-1:0] sample;
  logic [QUANT_W-1:0]  quantile;

  modport source (output valid, output op, output sample, output quantile, input ready);
  modport sink   (input valid, input op, input sample, input quantile, output ready);
endinterface

FILE: rtl/swpt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_result_if
// Output channel: statistics and the selected window sample.
// ----------------------------------------------------------------------------
interface swpt_result_if import swpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  total_count;
  logic [SUM_W-1:0]    total_sum;
  logic [SAMPLE_W-1:0] smallest;
  logic [SAMPLE_W-1:0] largest;
  logic [SAMPLE_W-1:0] selected;
  logic [WFILL_W-1:0]  window_fill;

  modport source (output valid, output total_count, output total_sum, output smallest,
                  output largest, output selected, output window_fill, input ready);
  modport sink   (input valid, input total_count, input total_sum, input smallest,
                  input largest, input selected, input window_fill, output ready);
endinterface

FILE: rtl/sliding_window_percentile_tracker_core.sv
`timescale 1ns / 1ps
// A record word passes through INSERT and EMIT, a query through GATHER, REDUCE and EMIT.
// EMIT waits for the sink; one word in flight at a time, no new word until the result loads.
// The query path runs through the two-stage registered rank select over the cell chain.
// Reset: synchronous; clears count, sum, maximum, fill, write slot and output valid, sets minimum to all ones.
// Window cells and the sample memory are not cleared; the fill count keeps them unread.
// ----------------------------------------------------------------------------
// sliding_window_percentile_tracker_core
// Latency statistics plus a sorted window of the last WINDOW samples, kept
// ordered by a chain of cells, from which any quantile can be read.
// ----------------------------------------------------------------------------
module sliding_window_percentile_tracker_core import swpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  swpt_item_if.sink            item,
  swpt_result_if.source        result
);

  // --------------------------------------------------------------------------
  // Control and statistics state
  // --------------------------------------------------------------------------
  swpt_state_t          state;
  swpt_state_t          state_next;

  logic [FILL_W-1:0]    fill;
  logic [IDX_W-1:0]     write_slot;
  logic [COUNT_W-1:0]   sample_count;
  logic [SUM_W-1:0]     sample_sum;
  logic [SAMPLE_W-1:0]  min_seen;
  logic [SAMPLE_W-1:0]  max_seen;

  logic                 op_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [SAMPLE_W-1:0]  evict_q;
  logic [IDX_W-1:0]     rank_q;
  logic                 empty_q;

  logic                 accept;
  logic                 upd_cells;
  logic                 grp_en;
  logic                 sel_en;
  logic                 load_out;
  logic                 full;

  logic [QUANT_W+FILL_W-1:0] rank_prod;
  logic [FILL_W:0]           rank_raw;
  logic [IDX_W-1:0]          rank_next;
  logic [SUM_W:0]            sum_ext;

  logic [SAMPLE_W-1:0]  window_mem [WINDOW];

  logic [SAMPLE_W-1:0]  cell_val   [WINDOW];
  swpt_flags_t          cell_flags [WINDOW];
  swpt_ctrl_t           ctrl;
  logic [SAMPLE_W-1:0]  sel;

  assign accept = item.valid && item.ready;
  assign full   = (fill == FILL_W'(WINDOW));

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.op == OP_QUERY) ? ST_GATHER : ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_EMIT;
      ST_GATHER: state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!result.valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    item.ready = 1'b0;
    upd_cells  = 1'b0;
    grp_en     = 1'b0;
    sel_en     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE:   item.ready = 1'b1;
      ST_INSERT: upd_cells  = 1'b1;
      ST_GATHER: grp_en     = 1'b1;
      ST_REDUCE: sel_en     = 1'b1;
      ST_EMIT:   load_out   = !result.valid || result.ready;
      default:   item.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Rank of the query: floor(quantile * fill / 2^16), clamped to fill - 1.
  // --------------------------------------------------------------------------
  always_comb begin
    rank_prod = (QUANT_W + FILL_W)'(item.quantile) * (QUANT_W + FILL_W)'(fill);
    rank_raw  = rank_prod[QUANT_W+FILL_W-1:QFRAC_W];
    if (rank_raw >= {1'b0, fill}) begin
      rank_next = IDX_W'(fill - FILL_W'(1));
    end else begin
      rank_next = rank_raw[IDX_W-1:0];
    end
  end

  // Latch the word; a query also latches its rank and whether the window is empty.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= item.op;
      sample_q <= item.sample;
      rank_q   <= rank_next;
      empty_q  <= (fill == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Sample memory in arrival order: the slot about to be overwritten holds
  // the oldest sample, which is the one to drop from the sorted chain.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && item.op == OP_RECORD) begin
      window_mem[write_slot] <= item.sample;
      evict_q                <= window_mem[write_slot];
    end
  end

  // --------------------------------------------------------------------------
  // Statistics, fill and write slot advance once the cells take the sample.
  // --------------------------------------------------------------------------
  assign sum_ext = {1'b0, sample_sum} + (SUM_W + 1)'(sample_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      write_slot   <= '0;
      sample_count <= '0;
      sample_sum   <= '0;
      min_seen     <= '1;
      max_seen     <= '0;
    end else if (upd_cells) begin
      if (!full) begin
        fill <= fill + FILL_W'(1);
      end
      if (write_slot == IDX_W'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + IDX_W'(1);
      end
      if (sample_count != '1) begin
        sample_count <= sample_count + COUNT_W'(1);
      end
      // Hold the sum at all ones on overflow.
      sample_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (sample_q < min_seen) begin
        min_seen <= sample_q;
      end
      if (sample_q > max_seen) begin
        max_seen <= sample_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sorted chain of cells. Cell i is occupied when i < fill. Each cell looks
  // only at its own and its neighbors' order flags to drop the evicted sample
  // and open a gap for the new one.
  // --------------------------------------------------------------------------
  always_comb begin
    ctrl.upd    = upd_cells;
    ctrl.full   = full;
    ctrl.sample = sample_q;
    ctrl.evict  = evict_q;
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swpt_flags_t         left_flags;
    logic                right_gt;
    logic [SAMPLE_W-1:0] left_val;
    logic [SAMPLE_W-1:0] right_val;
    logic                valid;

    assign valid = (FILL_W'(i) < fill);

    if (i == 0) begin : g_first
      assign left_flags = '0;
      assign left_val   = '0;
    end else begin : g_mid_left
      assign left_flags = cell_flags[i-1];
      assign left_val   = cell_val[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_gt  = 1'b1;
      assign right_val = '0;
    end else begin : g_mid_right
      assign right_gt  = cell_flags[i+1].gt;
      assign right_val = cell_val[i+1];
    end

    swpt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid),
      .left_flags (left_flags),
      .right_gt   (right_gt),
      .left_val   (left_val),
      .right_val  (right_val),
      .flags      (cell_flags[i]),
      .val        (cell_val[i])
    );
  end

  // --------------------------------------------------------------------------
  // Rank readout
  // --------------------------------------------------------------------------
  swpt_rank_sel u_rank_sel (
    .clk    (clk),
    .grp_en (grp_en),
    .sel_en (sel_en),
    .rank   (rank_q),
    .empty  (empty_q),
    .vals   (cell_val),
    .sel    (sel)
  );

  // --------------------------------------------------------------------------
  // Output register: hold the word until the sink takes it.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.total_count <= sample_count;
      result.total_sum   <= sample_sum;
      result.smallest    <= min_seen;
      result.largest     <= max_seen;
      result.selected    <= (op_q == OP_QUERY) ? sel : '0;
      result.window_fill <= WFILL_W'(fill);
    end
  end

`ifndef ASSERT_OFF
  a_fill_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT && !full) |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("fill did not advance on record");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !full |-> (write_slot == IDX_W'(fill)))
    else $error("write slot out of step with fill");

  a_empty_query_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE && empty_q) |=> (sel == '0))
    else $error("query on empty window selected nonzero");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result.valid)
    else $error("result word lost after load");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |=> (sample_count != '0))
    else $error("count zero after record");
`endif

endmodule

FILE: rtl/swpt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_cell
// One slot of the sorted window: drops the evicted sample and inserts the
// new one by taking a value from its left or right neighbor or the input.
// ----------------------------------------------------------------------------
module swpt_cell import swpt_pkg::*; (
  input  logic                clk,
  input  swpt_ctrl_t          ctrl,
  input  logic                valid,
  input  swpt_flags_t         left_flags,
  input  logic                right_gt,
  input  logic [SAMPLE_W-1:0] left_val,
  input  logic [SAMPLE_W-1:0] right_val,
  output swpt_flags_t         flags,
  output logic [SAMPLE_W-1:0] val
);

  logic take_left;
  logic take_new;
  logic take_right;

  always_comb begin
    flags.gt = !valid || (val > ctrl.sample);
    flags.ge = ctrl.full ? (val >= ctrl.evict) : !valid;
  end

  // Shift right between insert and evict points, left between evict and insert.
  always_comb begin
    take_left  = left_flags.gt && !left_flags.ge;
    take_new   = (flags.gt && !left_flags.gt && !left_flags.ge)
              || (!flags.gt && right_gt && flags.ge);
    take_right = flags.ge && !right_gt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      priority if (take_left) begin
        val <= left_val;
      end else if (take_new) begin
        val <= ctrl.sample;
      end else if (take_right) begin
        val <= right_val;
      end else begin
        val <= val;
      end
    end
  end

endmodule

FILE: rtl/swpt_rank_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_rank_sel
// Two-stage registered select of the cell at the requested rank.
// ----------------------------------------------------------------------------
module swpt_rank_sel import swpt_pkg::*; (
  input  logic                clk,
  input  logic                grp_en,
  input  logic                sel_en,
  input  logic [IDX_W-1:0]    rank,
  input  logic                empty,
  input  logic [SAMPLE_W-1:0] vals [WINDOW],
  output logic [SAMPLE_W-1:0] sel
);

  logic [SAMPLE_W-1:0] grp_or   [NGRP];
  logic [SAMPLE_W-1:0] grp_q    [NGRP];
  logic [SAMPLE_W-1:0] sel_next;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if ((g * GROUP + j) < WINDOW) begin
          if (rank == IDX_W'(g * GROUP + j)) begin
            grp_or[g] = grp_or[g] | vals[g * GROUP + j];
          end
        end
      end
    end
  end

  always_comb begin
    sel_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      sel_next = sel_next | grp_q[g];
    end
    if (empty) begin
      sel_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      grp_q <= grp_or;
    end
    if (sel_en) begin
      sel <= sel_next;
    end
  end

endmodule
